@@ src/wgm_pkg.sv @@
package wgm_pkg;

    // Default pattern capacity in characters.
    localparam int MAX_PATTERN_DEF = 32;

    // Wildcard characters.
    localparam logic [7:0] CH_ONE = 8'h3F;
    localparam logic [7:0] CH_ANY = 8'h2A;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    // Controls broadcast along the row of pattern cells.
    typedef struct packed {
        logic       load;
        logic [7:0] char_value;
    } t_cell_ctrl;

    // ASCII upper-casing of lower-case letters only.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

@@ src/wgm_if.sv @@
// Request channel: one command with its character.
interface wgm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] char_value;

    modport source (output valid, output cmd, output char_value, input ready);
    modport sink   (input valid, input cmd, input char_value, output ready);
endinterface

// Result channel: one report per end of word.
interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

@@ src/wgm_cell.sv @@
// One pattern position: holds its character and whether it is active.
module wgm_cell
    import wgm_pkg::*;
#(
    parameter bit IS_FIRST = 1'b0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_wr,
    input  logic       i_valid,
    input  logic       i_active_next,
    output logic       o_active,
    output logic       o_star,
    output logic       o_stay,
    output logic       o_adv
);

    logic [7:0] r_char;
    logic       r_active;
    logic       w_is_star;
    logic       w_hit;

    // Pattern character, written only on append at this position.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_char <= i_ctrl.char_value;
        end
    end

    // Active flag, reloaded with the closed set on every request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= IS_FIRST;
        end else if (i_ctrl.load) begin
            r_active <= i_active_next;
        end
    end

    // A star keeps the position; a question mark or an equal letter moves on.
    assign w_is_star = (r_char == CH_ANY);
    assign w_hit     = (r_char == CH_ONE) ||
                       (fold_case(r_char) == fold_case(i_ctrl.char_value));

    assign o_active = r_active;
    assign o_star   = i_valid && w_is_star;
    assign o_stay   = i_valid && r_active && w_is_star;
    assign o_adv    = i_valid && r_active && !w_is_star && w_hit;

endmodule

@@ src/wildcard_glob_matcher_unit.sv @@
// Glob matcher for streamed words. A request either clears the pattern,
// appends one character, feeds one text character or ends the word; only
// the end of a word returns a result, holding the match flag and the
// overflow flag. A new request is taken in every cycle while the result
// register is free or being emptied. The
// pattern sits in a row of MAX_PATTERN cells, each holding one character
// and one active bit; all cells step on a text character at once, and the
// skip-over of star runs is resolved across the row by one carry chain of
// MAX_PATTERN+1 bits, which sets the cycle time. No clearing pass is needed
// after reset.
module wildcard_glob_matcher_unit
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wgm_in_if.sink    i_req,
    wgm_out_if.source o_res
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_ovf, n_ovf;
    logic                 r_act_last;
    logic                 r_out_valid;
    logic                 r_matched;
    logic                 r_out_ovf;

    logic                 w_accept;
    t_cmd                 w_cmd;
    t_cell_ctrl           w_ctrl;
    logic [MAX_PATTERN-1:0] w_wr, w_valid, w_active, w_star, w_stay, w_adv;
    logic [MAX_PATTERN-1:0] w_star_new;
    logic [MAX_PATTERN:0]   w_raw, w_closed, w_act_all;
    logic [MAX_PATTERN:0]   w_ca, w_cb, w_sum, w_carry;

    assign w_cmd    = t_cmd'(i_req.cmd);
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_accept = i_req.valid && i_req.ready;

    assign w_ctrl.load       = w_accept;
    assign w_ctrl.char_value = i_req.char_value;

    // Row of pattern cells.
    for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
        assign w_valid[p] = LEN_W'(p) < r_len;
        assign w_wr[p]    = w_accept && (w_cmd == CMD_APPEND) && (r_len == LEN_W'(p));

        wgm_cell #(
            .IS_FIRST (p == 0)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_wr          (w_wr[p]),
            .i_valid       (w_valid[p]),
            .i_active_next (w_closed[p]),
            .o_active      (w_active[p]),
            .o_star        (w_star[p]),
            .o_stay        (w_stay[p]),
            .o_adv         (w_adv[p])
        );

        // Star flags of the pattern as it stands after this request.
        assign w_star_new[p] = w_wr[p] ? (i_req.char_value == CH_ANY) : w_star[p];
    end

    assign w_act_all = {r_act_last, w_active};

    // Raw next set and star pattern that the closure works over.
    logic [MAX_PATTERN-1:0] w_star_use;
    always_comb begin
        w_raw      = '0;
        w_raw[0]   = 1'b1;
        w_star_use = w_star;
        unique case (w_cmd)
            CMD_CLEAR: begin
                w_star_use = '0;
            end
            CMD_APPEND: begin
                w_star_use = w_star_new;
            end
            CMD_TEXT: begin
                w_raw = {1'b0, w_stay} | {w_adv, 1'b0};
            end
            CMD_END: begin
                w_star_use = w_star;
            end
            default: begin
                w_star_use = w_star;
            end
        endcase
    end

    // Star runs pass activity forward: a carry with star as propagate and
    // active star as generate.
    assign w_ca     = {1'b0, w_star_use};
    assign w_cb     = {1'b0, w_star_use & w_raw[MAX_PATTERN-1:0]};
    assign w_sum    = w_ca + w_cb;
    assign w_carry  = w_sum ^ w_ca ^ w_cb;
    assign w_closed = w_raw | w_carry;

    // Pattern length and overflow flag.
    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (w_accept && w_cmd == CMD_CLEAR) begin
            n_len = '0;
            n_ovf = 1'b0;
        end else if (w_accept && w_cmd == CMD_APPEND) begin
            if (r_len < LEN_W'(MAX_PATTERN)) begin
                n_len = r_len + LEN_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_act_last <= (MAX_PATTERN == 0);
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            if (w_accept) begin
                r_act_last <= w_closed[MAX_PATTERN];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_cmd == CMD_END) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_cmd == CMD_END) begin
            r_matched <= w_act_all[r_len] && !r_ovf;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.matched          = r_matched;
    assign o_res.pattern_overflow = r_out_ovf;

    // The length never passes the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    // A clear leaves an empty pattern without overflow.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == CMD_CLEAR) |=> (r_len == '0 && !r_ovf))
        else $error("clear did not empty the pattern");

    // An end of word always produces a result in the next cycle.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd == CMD_END) |=> r_out_valid)
        else $error("end of word gave no result");

    // An overflowing pattern never reports a match.
    a_ovf_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_matched && r_out_ovf))
        else $error("match reported with overflow");

endmodule
